FILE: rtl/gtga_pkg.sv
package gtga_pkg;

    // Result kinds reported on the glyph_kind field.
    localparam logic [2:0] KIND_ASCII   = 3'd0;
    localparam logic [2:0] KIND_HANZI   = 3'd1;
    localparam logic [2:0] KIND_SKIPPED = 3'd2;
    localparam logic [2:0] KIND_ABORTED = 3'd3;
    localparam logic [2:0] KIND_ENDED   = 3'd4;

    // Code layout of the double-byte character set.
    localparam logic [7:0] LEAD_MIN  = 8'hA0;
    localparam logic [6:0] ZONE_MAX  = 7'd87;
    localparam logic [6:0] POS_MAX   = 7'd94;
    localparam logic [6:0] GAP_FIRST = 7'd10;
    localparam logic [6:0] GAP_LAST  = 7'd15;
    localparam logic [6:0] ZONE_GAP  = 7'd6;

    // One hanzi glyph is 32 bytes, one zone row holds 94 glyphs.
    localparam logic [17:0] ROW_BYTES = 18'd3008;

    // Pen advance in pixels.
    localparam logic [15:0] ASCII_ADVANCE = 16'd8;
    localparam logic [15:0] HANZI_ADVANCE = 16'd16;

    typedef struct packed {
        logic [2:0]  kind;
        logic [17:0] address;
        logic [15:0] pen_x;
    } t_glyph;

endpackage

FILE: rtl/gb2312_text_glyph_addresser_top.sv
// Each glyph result is registered. Throughput: one byte per cycle while the input is not stalled;
// the single result register is refilled while it is emptied.
// Input stall rises only when the result register is full and the output side is stalled.
// Reset (synchronous, active low) clears the lead-pending flag, the abort flag and the result
// valid, and sets the origin and the pen position to zero.
module gb2312_text_glyph_addresser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_glyph_kind,
    output logic [17:0] o_glyph_address,
    output logic [15:0] o_pen_x
);

    logic [15:0] r_origin;
    logic [15:0] r_pen;
    logic [15:0] n_pen;
    logic        r_pending;
    logic        n_pending;
    logic [6:0]  r_zone;
    logic        r_aborted;
    logic        n_aborted;
    logic        r_out_valid;
    gtga_pkg::t_glyph r_out;
    gtga_pkg::t_glyph n_out;
    logic        n_emit;

    logic        accept;
    logic        is_lead;
    logic [6:0]  pos;
    logic [6:0]  zone_adj;
    logic [6:0]  zone_m1;
    logic [6:0]  pos_m1;
    logic        pair_bad;
    logic [17:0] hanzi_addr;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    // The result register frees itself whenever the output side takes its transaction.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // Zone and position of a double-byte pair, with the gap zones folded out.
    assign is_lead    = (i_text_byte >= gtga_pkg::LEAD_MIN);
    assign pos        = 7'(i_text_byte - gtga_pkg::LEAD_MIN);
    assign zone_adj   = (r_zone > gtga_pkg::GAP_LAST) ? (r_zone - gtga_pkg::ZONE_GAP) : r_zone;
    assign zone_m1    = zone_adj - 7'd1;
    assign pos_m1     = pos - 7'd1;
    assign pair_bad   = (r_zone == 7'd0) || (pos == 7'd0) ||
                        (r_zone > gtga_pkg::ZONE_MAX) || (pos > gtga_pkg::POS_MAX) ||
                        ((r_zone >= gtga_pkg::GAP_FIRST) && (r_zone <= gtga_pkg::GAP_LAST));
    assign hanzi_addr = (18'(zone_m1) * gtga_pkg::ROW_BYTES) + {6'd0, pos_m1, 5'd0};

    // Decode one byte against the string state.
    always_comb begin
        n_pen        = r_pen;
        n_pending    = r_pending;
        n_aborted    = r_aborted;
        n_emit       = 1'b0;
        n_out.kind    = gtga_pkg::KIND_ENDED;
        n_out.address = 18'd0;
        n_out.pen_x   = r_pen;
        if (r_pending) begin
            n_emit    = 1'b1;
            n_pending = 1'b0;
            if (!is_lead) begin
                // A trail byte below the lead range aborts the string.
                n_out.kind = gtga_pkg::KIND_ABORTED;
                if (i_text_byte == 8'd0) begin
                    n_aborted = 1'b0;
                    n_pen     = r_origin;
                end else begin
                    n_aborted = 1'b1;
                end
            end else begin
                n_pen = r_pen + gtga_pkg::HANZI_ADVANCE;
                if (pair_bad) begin
                    n_out.kind = gtga_pkg::KIND_SKIPPED;
                end else begin
                    n_out.kind    = gtga_pkg::KIND_HANZI;
                    n_out.address = hanzi_addr;
                end
            end
        end else if (i_text_byte == 8'd0) begin
            // End of string: everything returns to the origin.
            n_emit     = 1'b1;
            n_out.kind = gtga_pkg::KIND_ENDED;
            n_aborted  = 1'b0;
            n_pen      = r_origin;
        end else if (!r_aborted) begin
            if (is_lead) begin
                n_pending = 1'b1;
            end else begin
                n_emit        = 1'b1;
                n_out.kind    = gtga_pkg::KIND_ASCII;
                n_out.address = {6'd0, i_text_byte, 4'd0};
                n_pen         = r_pen + gtga_pkg::ASCII_ADVANCE;
            end
        end
    end

    // String state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin  <= 16'd0;
            r_pen     <= 16'd0;
            r_pending <= 1'b0;
            r_aborted <= 1'b0;
        end else if (i_cfg_valid) begin
            r_origin <= i_cfg_data;
            r_pen    <= i_cfg_data;
        end else if (accept) begin
            r_pen     <= n_pen;
            r_pending <= n_pending;
            r_aborted <= n_aborted;
        end
    end

    // The lead byte is kept as its zone number.
    always_ff @(posedge i_clk) begin
        if (accept && !r_pending && is_lead) begin
            r_zone <= pos;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_glyph_kind    = r_out.kind;
    assign o_glyph_address = r_out.address;
    assign o_pen_x         = r_out.pen_x;

endmodule

FILE: bench/tb_gb2312_text_glyph_addresser_top.sv
module tb_gb2312_text_glyph_addresser_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_LIMIT = 5000;
    localparam int unsigned CODE_BIAS   = 160;
    localparam int unsigned GLYPH_BYTES = 32;

    // This class predicts the glyph stream and keeps the glyphs still owed by the block.
    class glyph_tracker;
        logic [15:0]      origin;
        logic [15:0]      pen;
        logic [7:0]       held_lead;
        logic             lead_pending;
        logic             aborted;
        gtga_pkg::t_glyph owed_glyphs[$];
        int               mismatches;

        function new();
            origin       = '0;
            mismatches   = 0;
            close_string();
        endfunction

        function void close_string();
            held_lead    = '0;
            lead_pending = 1'b0;
            aborted      = 1'b0;
            pen          = origin;
        endfunction

        // A register write also moves the pen to the new origin.
        function void load_origin(logic [15:0] value);
            origin = value;
            pen    = value;
        endfunction

        function int outstanding();
            return owed_glyphs.size();
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: glyph mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Works out the glyph that one accepted text byte causes, if any.
        function void note_byte(logic [7:0] b);
            gtga_pkg::t_glyph g;
            logic             emits;
            int unsigned      zone;
            int unsigned      pos;
            emits     = 1'b1;
            g.kind    = gtga_pkg::KIND_ASCII;
            g.address = '0;
            g.pen_x   = pen;
            if (lead_pending) begin
                if (b < gtga_pkg::LEAD_MIN) begin
                    // A non-hanzi trail byte aborts; a zero trail also ends the string.
                    g.kind = gtga_pkg::KIND_ABORTED;
                    if (b == 8'h00) begin
                        close_string();
                    end else begin
                        lead_pending = 1'b0;
                        held_lead    = '0;
                        aborted      = 1'b1;
                    end
                end else begin
                    zone         = int'(held_lead) - CODE_BIAS;
                    pos          = int'(b) - CODE_BIAS;
                    lead_pending = 1'b0;
                    held_lead    = '0;
                    pen          = pen + gtga_pkg::HANZI_ADVANCE;
                    if (zone == 0 || pos == 0 || zone > gtga_pkg::ZONE_MAX ||
                        pos > gtga_pkg::POS_MAX ||
                        (zone >= gtga_pkg::GAP_FIRST && zone <= gtga_pkg::GAP_LAST)) begin
                        g.kind = gtga_pkg::KIND_SKIPPED;
                    end else begin
                        if (zone > gtga_pkg::GAP_LAST) begin
                            zone = zone - gtga_pkg::ZONE_GAP;
                        end
                        g.kind    = gtga_pkg::KIND_HANZI;
                        g.address = 18'((zone - 1) * gtga_pkg::ROW_BYTES +
                                        (pos - 1) * GLYPH_BYTES);
                    end
                end
            end else if (b == 8'h00) begin
                g.kind = gtga_pkg::KIND_ENDED;
                close_string();
            end else if (aborted) begin
                emits = 1'b0;
            end else if (b < gtga_pkg::LEAD_MIN) begin
                g.kind    = gtga_pkg::KIND_ASCII;
                g.address = 18'({b, 4'h0});
                pen       = pen + gtga_pkg::ASCII_ADVANCE;
            end else begin
                held_lead    = b;
                lead_pending = 1'b1;
                emits        = 1'b0;
            end
            if (emits) begin
                owed_glyphs.push_back(g);
            end
        endfunction

        // Compares one glyph transaction from the block with the oldest owed glyph.
        task check_glyph(logic [2:0] kind, logic [17:0] address, logic [15:0] pen_x);
            gtga_pkg::t_glyph want;
            if (owed_glyphs.size() == 0) begin
                report_mismatch($sformatf("unexpected glyph kind %0d address %0h pen %0h",
                                          kind, address, pen_x));
                return;
            end
            want = owed_glyphs.pop_front();
            if (kind !== want.kind) begin
                report_mismatch($sformatf("kind %0d, predicted %0d", kind, want.kind));
            end
            if (address !== want.address) begin
                report_mismatch($sformatf("address %0h, predicted %0h (kind %0d)",
                                          address, want.address, want.kind));
            end
            if (pen_x !== want.pen_x) begin
                report_mismatch($sformatf("pen %0h, predicted %0h (kind %0d)",
                                          pen_x, want.pen_x, want.kind));
            end
        endtask

        task check_drained();
            if (owed_glyphs.size() != 0) begin
                report_mismatch($sformatf("%0d glyphs never arrived", owed_glyphs.size()));
            end
        endtask
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [15:0] i_cfg_data      = '0;
    logic        i_in_valid      = 1'b0;
    logic [7:0]  i_text_byte     = '0;
    logic        i_out_stall     = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_glyph_kind;
    logic [17:0] o_glyph_address;
    logic [15:0] o_pen_x;

    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    logic         holding_off   = 1'b0;
    int           cycle_count   = 0;
    glyph_tracker tracker       = new();

    gb2312_text_glyph_addresser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_text_byte     (i_text_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_glyph_kind    (o_glyph_kind),
        .o_glyph_address (o_glyph_address),
        .o_pen_x         (o_pen_x)
    );

    always #10 i_clk = ~i_clk;

    // Run limit: a stuck block or a lost glyph ends here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Receiver stall: random idling, or a long hold-off when one is running.
    always @(posedge i_clk) begin
        i_out_stall <= holding_off || ($urandom_range(99) < recv_idle_pct);
    end

    // Monitors sample the values that stood at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            tracker.note_byte(i_text_byte);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_glyph(o_glyph_kind, o_glyph_address, o_pen_x);
        end
    end

    // Offers one text byte, with random idle cycles first, until the transaction is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_origin(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        tracker.load_origin(value);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every owed glyph has come or DRAIN_LIMIT runs out, then lets a held lead byte settle.
    task automatic settle();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic hold_receiver(input int cycles);
        holding_off <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        holding_off <= 1'b0;
    endtask

    // Random text: mostly well-formed strings, with bad pairs, aborts and raw noise.
    task automatic play_random(input int byte_goal);
        int          sent;
        int          pick;
        int unsigned zone;
        int          extra;
        sent = 0;
        while (sent < byte_goal) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_byte(8'($urandom_range(8'h9F, 8'h01)));
                sent += 1;
            end else if (pick < 75) begin
                zone = $urandom_range(81, 1);
                if (zone >= gtga_pkg::GAP_FIRST) begin
                    zone = zone + gtga_pkg::ZONE_GAP;
                end
                send_byte(8'(zone + CODE_BIAS));
                send_byte(8'($urandom_range(gtga_pkg::POS_MAX, 1) + CODE_BIAS));
                sent += 2;
            end else if (pick < 83) begin
                send_byte(8'($urandom_range(8'hFF, 8'hA0)));
                send_byte(8'($urandom_range(8'hFF, 8'hA0)));
                sent += 2;
            end else if (pick < 88) begin
                send_byte(8'h00);
                sent += 1;
            end else if (pick < 93) begin
                send_byte(8'($urandom_range(8'hFF, 8'hA0)));
                send_byte(8'($urandom_range(8'h9F)));
                sent += 2;
                extra = $urandom_range(3);
                repeat (extra) send_byte(8'($urandom_range(8'hFF, 8'h01)));
            end else begin
                send_byte(8'($urandom_range(8'hFF)));
                sent += 1;
            end
        end
    endtask

    initial begin
        logic [7:0] directed_text[$];
        // ASCII extremes, hanzi corners, each invalid pair kind, abort with ignored bytes,
        // zero as trail byte, and a plain terminator.
        directed_text = '{8'h01, 8'h7F, 8'h9F,
                          8'hA1, 8'hA1, 8'hB0, 8'hA1, 8'hF7, 8'hFE,
                          8'hA0, 8'hA1, 8'hA1, 8'hA0, 8'hAA, 8'hA1, 8'hF8, 8'hA1,
                          8'hA1, 8'hFF,
                          8'hA1, 8'h41, 8'h55, 8'h00,
                          8'hB0, 8'h00, 8'h00};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: sender idles now and then, receiver mostly stalls.
        send_idle_pct = 23;
        recv_idle_pct = 75;
        write_origin(16'hFFF8);
        foreach (directed_text[k]) begin
            send_byte(directed_text[k]);
        end
        settle();
        write_origin(16'hFFFF);
        play_random(400);
        settle();

        // Phase two: the other way round.
        send_idle_pct = 75;
        recv_idle_pct = 23;
        write_origin(16'h0000);
        play_random(400);
        settle();

        // Phase three: no idling, with one long receiver hold-off to fill the block.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_origin(16'($urandom));
        fork
            hold_receiver(300);
            play_random(150);
        join
        play_random(250);
        settle();

        tracker.check_drained();
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
